[sv/stagu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stagu_pkg
// Shared types, constants, sine table and sequencer codes for the scripted
// test-audio generator.
// ----------------------------------------------------------------------------
package stagu_pkg;

    localparam int SINE_BITS     = 10;
    localparam int SINE_ENTRIES  = 1 << SINE_BITS;
    localparam int SINE_QTR      = SINE_ENTRIES / 4;
    localparam int QTR_BITS      = SINE_BITS - 2;
    localparam int FRAME_SAMPLES = 320;
    localparam int SIF_W         = 10;
    localparam int SCRIPT_FRAMES = 250;
    localparam int SCRIPT_W      = 8;
    localparam int SWEEP_LEN     = 8000;
    localparam int SWEEP_W       = 13;
    localparam int STEP_W        = 4;
    localparam int LAST_STEP     = 14;
    localparam int REM_W         = 22;

    localparam logic [31:0] LCG_A = 32'd1664525;
    localparam logic [31:0] LCG_C = 32'd1013904223;
    localparam longint      Q30_L = 64'sd1073741824;

    typedef enum logic [2:0] {
        CASE_SILENCE = 3'd0,
        CASE_NOISE   = 3'd1,
        CASE_SPEECH  = 3'd2,
        CASE_WAKE    = 3'd3,
        CASE_POST    = 3'd4
    } case_t;

    localparam logic [2:0] MODE_SCRIPT = 3'd5;

    typedef struct packed {
        logic [2:0] mode;
        logic       restart;
    } req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [2:0]         case_used;
        logic               frame_end;
    } rsp_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_NOISE, MUL_ENVPH, MUL_GAIN, MUL_ENVG,
        MUL_PH1, MUL_PH2, MUL_PH3, MUL_AMP1, MUL_AMP2, MUL_AMP3, MUL_ETONE
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE, WB_NOISE, WB_OSC, WB_NTERM, WB_ENV, WB_TONE_LD, WB_TONE_ADD, WB_TOTAL
    } wb_sel_t;

    typedef struct packed {
        logic     start;
        logic     restart;
        logic     finish;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
    } ctrl_cmd_t;

    // frequency words, floor(f * 2^32 / 16000), f in tenths of Hz
    localparam logic [31:0] W_ENV_SP = 32'((64'd50    << 32) / 64'd160000);
    localparam logic [31:0] W_SP1    = 32'((64'd1200  << 32) / 64'd160000);
    localparam logic [31:0] W_SP2    = 32'((64'd7000  << 32) / 64'd160000);
    localparam logic [31:0] W_SP3    = 32'((64'd12200 << 32) / 64'd160000);
    localparam logic [31:0] W_ENV_WK = 32'((64'd30    << 32) / 64'd160000);
    localparam logic [31:0] W_ENV_PS = 32'((64'd65    << 32) / 64'd160000);
    localparam logic [31:0] W_PS1    = 32'((64'd1650  << 32) / 64'd160000);
    localparam logic [31:0] W_PS2    = 32'((64'd8200  << 32) / 64'd160000);
    localparam logic [31:0] W_PS3    = 32'((64'd16000 << 32) / 64'd160000);

    // sweep tones: word = floor((base + step * s) * 2^32 / den)
    localparam logic [31:0] SWP_W0 [3] = '{
        32'((64'd30000  << 32) / 64'd3200000),
        32'((64'd14400  << 32) / 64'd256000),
        32'((64'd192000 << 32) / 64'd1280000)};
    localparam logic [REM_W-1:0] SWP_R0 [3] = '{
        REM_W'((64'd30000  << 32) % 64'd3200000),
        REM_W'((64'd14400  << 32) % 64'd256000),
        REM_W'((64'd192000 << 32) % 64'd1280000)};
    localparam logic [31:0] SWP_WS [3] = '{
        32'((64'd1 << 32) / 64'd3200000),
        32'((64'd3 << 32) / 64'd256000),
        32'((64'd9 << 32) / 64'd1280000)};
    localparam logic [REM_W-1:0] SWP_RS [3] = '{
        REM_W'((64'd1 << 32) % 64'd3200000),
        REM_W'((64'd3 << 32) % 64'd256000),
        REM_W'((64'd9 << 32) % 64'd1280000)};
    localparam logic [REM_W:0] SWP_DEN [3] = '{
        (REM_W+1)'(3200000), (REM_W+1)'(256000), (REM_W+1)'(1280000)};

    typedef logic signed [15:0] sine_qtr_t [SINE_QTR];

    function automatic logic signed [15:0] sine_mag(int unsigned k);
        longint unsigned v;
        longint          x;
        longint          x2;
        longint          term;
        longint          sum;
        longint          val;
        v    = longint'(k) << (32 - SINE_BITS);
        x    = longint'((v * 64'd1686629713) >> 30);
        x2   = (x * x) / Q30_L;
        term = x;
        sum  = x;
        term = -((term * x2) / Q30_L) / 64'sd6;   sum = sum + term;
        term = -((term * x2) / Q30_L) / 64'sd20;  sum = sum + term;
        term = -((term * x2) / Q30_L) / 64'sd42;  sum = sum + term;
        term = -((term * x2) / Q30_L) / 64'sd72;  sum = sum + term;
        term = -((term * x2) / Q30_L) / 64'sd110; sum = sum + term;
        term = -((term * x2) / Q30_L) / 64'sd156; sum = sum + term;
        val  = (sum * 64'sd32767 + (Q30_L / 2)) / Q30_L;
        if (val < 0)
        begin
            val = 0;
        end
        if (val > 32767)
        begin
            val = 32767;
        end
        return val[15:0];
    endfunction

    function automatic sine_qtr_t build_sine_qtr();
        sine_qtr_t t;
        for (int k = 0; k < SINE_QTR; k++)
        begin
            t[k] = sine_mag(k);
        end
        return t;
    endfunction

    localparam sine_qtr_t          SINE_TAB  = build_sine_qtr();
    localparam logic signed [15:0] SINE_PEAK = sine_mag(SINE_QTR);

    function automatic logic signed [15:0] sine_lookup(logic [SINE_BITS-1:0] idx);
        logic [QTR_BITS-1:0] off;
        logic [QTR_BITS-1:0] mir;
        logic signed [15:0]  mag;
        off = idx[QTR_BITS-1:0];
        mir = ~off + 1'b1;
        if (!idx[SINE_BITS-2])
        begin
            mag = SINE_TAB[off];
        end
        else if (off == '0)
        begin
            mag = SINE_PEAK;
        end
        else
        begin
            mag = SINE_TAB[mir];
        end
        return idx[SINE_BITS-1] ? -mag : mag;
    endfunction

endpackage
`default_nettype wire

[sv/stagu_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stagu_ctrl
// Handshake control and step sequencer for the shared multiplier datapath.
// ----------------------------------------------------------------------------
module stagu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic                req_restart,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output stagu_pkg::ctrl_cmd_t     cmd
);
    import stagu_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        cmd.wb_sel  = WB_NONE;
        cmd.start   = accept && !req_restart;
        cmd.restart = accept && req_restart;
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                4'd0:    begin cmd.mul_sel = MUL_NOISE; end
                4'd1:    begin cmd.mul_sel = MUL_ENVPH; cmd.wb_sel = WB_NOISE;    end
                4'd2:    begin cmd.mul_sel = MUL_GAIN;  cmd.wb_sel = WB_OSC;      end
                4'd3:    begin cmd.mul_sel = MUL_ENVG;  cmd.wb_sel = WB_NTERM;    end
                4'd4:    begin cmd.mul_sel = MUL_PH1;   cmd.wb_sel = WB_ENV;      end
                4'd5:    begin cmd.mul_sel = MUL_PH2;   cmd.wb_sel = WB_OSC;      end
                4'd6:    begin cmd.mul_sel = MUL_AMP1;  cmd.wb_sel = WB_OSC;      end
                4'd7:    begin cmd.mul_sel = MUL_AMP2;  cmd.wb_sel = WB_TONE_LD;  end
                4'd8:    begin cmd.mul_sel = MUL_PH3;   cmd.wb_sel = WB_TONE_ADD; end
                4'd9:    begin cmd.wb_sel  = WB_OSC;    end
                4'd10:   begin cmd.mul_sel = MUL_AMP3;  end
                4'd11:   begin cmd.wb_sel  = WB_TONE_ADD; end
                4'd12:   begin cmd.mul_sel = MUL_ETONE; end
                4'd13:   begin cmd.wb_sel  = WB_TOTAL;  end
                4'd14:   begin cmd.finish  = !rsp_valid_reg || !rsp_stall; end
                default: begin cmd.mul_sel = MUL_NONE;  end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (cmd.finish)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
                else if (step_reg != STEP_W'(LAST_STEP))
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule
`default_nettype wire

[sv/stagu_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stagu_dp
// Generator state, sweep word tracking, shared multiplier, mixing and
// result register.
// ----------------------------------------------------------------------------
module stagu_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire stagu_pkg::ctrl_cmd_t cmd,
    input  wire stagu_pkg::req_t      req,
    input  wire logic                 cfg_wr_en,
    input  wire logic [31:0]          cfg_wr_data,
    output stagu_pkg::rsp_t           rsp
);
    import stagu_pkg::*;

    logic [31:0]              seed_reg;
    logic [31:0]              phase_reg;
    logic [31:0]              noise_reg;
    logic [SWEEP_W-1:0]       sweep_reg;
    logic [SIF_W-1:0]         sif_reg;
    logic [SCRIPT_W-1:0]      script_reg;
    logic [31:0]              sw_word_reg [3];
    logic [REM_W-1:0]         sw_rem_reg  [3];
    case_t                    case_reg;
    logic                     mode5_reg;
    logic signed [47:0]       prod_reg;
    logic signed [15:0]       osc_reg;
    logic signed [28:0]       nterm_reg;
    logic signed [16:0]       env_reg;
    logic signed [30:0]       tones_reg;
    logic signed [47:0]       total_reg;
    rsp_t                     rsp_reg;

    case_t                    case_next;
    logic [31:0]              w_env;
    logic [31:0]              w1;
    logic [31:0]              w2;
    logic [31:0]              w3;
    logic [15:0]              amp1;
    logic [15:0]              amp2;
    logic [15:0]              amp3;
    logic [16:0]              env_base;
    logic [15:0]              env_g;
    logic [11:0]              gain;
    logic signed [15:0]       noise_r;
    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       product;
    logic signed [30:0]       eg;
    logic signed [30:0]       eg_b;
    logic signed [47:0]       biased;
    logic signed [17:0]       q;
    logic signed [15:0]       sample_sat;
    logic [SIF_W:0]           sif_inc;
    logic                     fend;
    logic [REM_W:0]           rem_sum [3];

    always_comb
    begin
        if (req.mode == MODE_SCRIPT)
        begin
            priority if (script_reg < SCRIPT_W'(70))   case_next = CASE_SILENCE;
            else if     (script_reg < SCRIPT_W'(105))  case_next = CASE_NOISE;
            else if     (script_reg < SCRIPT_W'(135))  case_next = CASE_SPEECH;
            else if     (script_reg < SCRIPT_W'(165))  case_next = CASE_WAKE;
            else if     (script_reg < SCRIPT_W'(225))  case_next = CASE_POST;
            else                                       case_next = CASE_SILENCE;
        end
        else
        begin
            unique case (req.mode)
                3'd1:    case_next = CASE_NOISE;
                3'd2:    case_next = CASE_SPEECH;
                3'd3:    case_next = CASE_WAKE;
                3'd4:    case_next = CASE_POST;
                default: case_next = CASE_SILENCE;
            endcase
        end
    end

    always_comb
    begin
        w_env    = W_ENV_SP;
        w1       = W_SP1;
        w2       = W_SP2;
        w3       = W_SP3;
        amp1     = 16'd7000;
        amp2     = 16'd3500;
        amp3     = 16'd1800;
        env_base = 17'd18022;
        env_g    = 16'd14746;
        unique case (case_reg)
            CASE_SILENCE: gain = 12'd52;
            CASE_NOISE:   gain = 12'd1966;
            CASE_SPEECH:  gain = 12'd3277;
            CASE_WAKE:
            begin
                gain     = 12'd3932;
                w_env    = W_ENV_WK;
                w1       = sw_word_reg[0];
                w2       = sw_word_reg[1];
                w3       = sw_word_reg[2];
                amp1     = 16'd6500;
                amp2     = 16'd4200;
                amp3     = 16'd2600;
                env_base = 17'd16384;
                env_g    = 16'd16384;
            end
            CASE_POST:
            begin
                gain     = 12'd3277;
                w_env    = W_ENV_PS;
                w1       = W_PS1;
                w2       = W_PS2;
                w3       = W_PS3;
                amp1     = 16'd6000;
                amp2     = 16'd3000;
                amp3     = 16'd1500;
                env_base = 17'd16384;
                env_g    = 16'd16384;
            end
            default:      gain = 12'd52;
        endcase
    end

    assign noise_r = {~noise_reg[31], noise_reg[30:16]};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_NOISE: begin mul_a = {1'b0, noise_reg}; mul_b = {1'b0, LCG_A}; end
            MUL_ENVPH: begin mul_a = {1'b0, phase_reg}; mul_b = {1'b0, w_env}; end
            MUL_GAIN:  begin mul_a = {{17{noise_r[15]}}, noise_r}; mul_b = {21'd0, gain}; end
            MUL_ENVG:  begin mul_a = {{17{osc_reg[15]}}, osc_reg}; mul_b = {17'd0, env_g}; end
            MUL_PH1:   begin mul_a = {1'b0, phase_reg}; mul_b = {1'b0, w1}; end
            MUL_PH2:   begin mul_a = {1'b0, phase_reg}; mul_b = {1'b0, w2}; end
            MUL_PH3:   begin mul_a = {1'b0, phase_reg}; mul_b = {1'b0, w3}; end
            MUL_AMP1:  begin mul_a = {{17{osc_reg[15]}}, osc_reg}; mul_b = {17'd0, amp1}; end
            MUL_AMP2:  begin mul_a = {{17{osc_reg[15]}}, osc_reg}; mul_b = {17'd0, amp2}; end
            MUL_AMP3:  begin mul_a = {{17{osc_reg[15]}}, osc_reg}; mul_b = {17'd0, amp3}; end
            MUL_ETONE: begin mul_a = {{16{env_reg[16]}}, env_reg};
                             mul_b = {{2{tones_reg[30]}}, tones_reg}; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign product = mul_a * mul_b;

    assign eg   = prod_reg[30:0];
    assign eg_b = eg + (eg[30] ? 31'sd32767 : 31'sd0);

    assign biased = total_reg + (total_reg[47] ? 48'sd1073741823 : 48'sd0);
    assign q      = biased[47:30];

    always_comb
    begin
        priority if (q > 18'sd32767)   sample_sat = 16'sh7FFF;
        else if     (q < -18'sd32768)  sample_sat = 16'sh8000;
        else                           sample_sat = q[15:0];
    end

    assign sif_inc = {1'b0, sif_reg} + 1'b1;
    assign fend    = (sif_inc >= (SIF_W+1)'(FRAME_SAMPLES));

    for (genvar t = 0; t < 3; t++)
    begin : g_rem
        assign rem_sum[t] = {1'b0, sw_rem_reg[t]} + {1'b0, SWP_RS[t]};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product[47:0];
        unique case (cmd.wb_sel)
            WB_OSC:      osc_reg   <= sine_lookup(prod_reg[31:32-SINE_BITS]);
            WB_NTERM:    nterm_reg <= prod_reg[28:0];
            WB_ENV:      env_reg   <= $signed(env_base) + {eg_b[30], eg_b[30:15]};
            WB_TONE_LD:  tones_reg <= prod_reg[30:0];
            WB_TONE_ADD: tones_reg <= tones_reg + prod_reg[30:0];
            WB_TOTAL:    total_reg <= ((case_reg == CASE_SILENCE || case_reg == CASE_NOISE)
                                       ? 48'sd0 : prod_reg)
                                      + {{5{nterm_reg[28]}}, nterm_reg, 14'd0};
            default:     ;
        endcase
        if (cmd.start)
        begin
            case_reg  <= case_next;
            mode5_reg <= (req.mode == MODE_SCRIPT);
        end
        if (cmd.finish)
        begin
            rsp_reg.sample    <= sample_sat;
            rsp_reg.case_used <= case_reg;
            rsp_reg.frame_end <= fend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            phase_reg  <= '0;
            noise_reg  <= '0;
            sweep_reg  <= '0;
            sif_reg    <= '0;
            script_reg <= '0;
            for (int t = 0; t < 3; t++)
            begin
                sw_word_reg[t] <= SWP_W0[t];
                sw_rem_reg[t]  <= SWP_R0[t];
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            if (cmd.wb_sel == WB_NOISE)
            begin
                noise_reg <= prod_reg[31:0] + LCG_C;
            end
            if (cmd.restart)
            begin
                noise_reg  <= seed_reg;
                phase_reg  <= '0;
                sweep_reg  <= '0;
                sif_reg    <= '0;
                script_reg <= '0;
                for (int t = 0; t < 3; t++)
                begin
                    sw_word_reg[t] <= SWP_W0[t];
                    sw_rem_reg[t]  <= SWP_R0[t];
                end
            end
            else if (cmd.finish)
            begin
                phase_reg <= phase_reg + 1'b1;
                if (fend)
                begin
                    sif_reg <= '0;
                    if (mode5_reg)
                    begin
                        script_reg <= (script_reg == SCRIPT_W'(SCRIPT_FRAMES - 1))
                                      ? '0 : script_reg + 1'b1;
                    end
                end
                else
                begin
                    sif_reg <= sif_inc[SIF_W-1:0];
                end
                if (sweep_reg == SWEEP_W'(SWEEP_LEN - 1))
                begin
                    sweep_reg <= '0;
                    for (int t = 0; t < 3; t++)
                    begin
                        sw_word_reg[t] <= SWP_W0[t];
                        sw_rem_reg[t]  <= SWP_R0[t];
                    end
                end
                else
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    for (int t = 0; t < 3; t++)
                    begin
                        if (rem_sum[t] >= SWP_DEN[t])
                        begin
                            sw_rem_reg[t]  <= REM_W'(rem_sum[t] - SWP_DEN[t]);
                            sw_word_reg[t] <= sw_word_reg[t] + SWP_WS[t] + 1'b1;
                        end
                        else
                        begin
                            sw_rem_reg[t]  <= rem_sum[t][REM_W-1:0];
                            sw_word_reg[t] <= sw_word_reg[t] + SWP_WS[t];
                        end
                    end
                end
            end
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

[sv/scripted_test_audio_generator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scripted_test_audio_generator_unit
// Test-audio sample generator: tones, envelope and noise per signal case.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req) carries mode and restart; each
// non-restart beat yields one beat on the response channel
// (rsp_valid/rsp_stall/rsp) with sample, case used and frame-end flag.
// A restart beat reloads the noise generator from noise seed (cfg_wr_en,
// cfg_wr_data), clears the counters and yields nothing.
// One shared 33x33 multiplier is stepped through a 15-step sequence of 11
// products per sample, so the block takes a new request only once the last
// one has run through that sequence; a restart beat does not occupy the
// sequencer.
// The response sits in an output register, so the next request is taken
// while a response waits. If a response is still stalled when the next one
// is ready, the sequencer holds on its last step and the request side stalls.
// Reset clears all counters, the noise state and the seed; the sine table
// is constant logic.
// ----------------------------------------------------------------------------
module scripted_test_audio_generator_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire stagu_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output stagu_pkg::rsp_t      rsp,
    input  wire logic            cfg_wr_en,
    input  wire logic [31:0]     cfg_wr_data
);
    import stagu_pkg::*;

    ctrl_cmd_t cmd;

    stagu_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_restart (req.restart),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .cmd         (cmd)
    );

    stagu_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp         (rsp)
    );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scripted test-audio generator testbench
// Sends mode and restart beats through a bursty, gappy sender and takes
// samples through a receiver with its own stall pattern. Every sample is
// checked field by field against a cycle-free model of the tones, envelopes,
// noise generator, frame counter and script held inside this bench.
// ----------------------------------------------------------------------------
module testbench;
    import stagu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    scripted_test_audio_generator_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    localparam int CYCLE_LIMIT = 600000;

    logic signed [15:0] sine_ref [SINE_ENTRIES];
    logic [31:0]        seed_reg;
    logic [31:0]        phase_acc;
    logic [31:0]        lcg;
    int unsigned        sweep_pos;
    int unsigned        frame_pos;
    int unsigned        script_pos;

    rsp_t        sample_queue [$];
    int          mismatches;
    longint      cycles;
    bit          hold_off;
    bit          no_gaps;
    int          hold_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [15:0] rom_entry(int unsigned i);
        longint unsigned u;
        longint unsigned v;
        int unsigned     quad;
        longint          x;
        longint          x2;
        longint          term;
        longint          sum;
        longint          val;
        u    = (longint'(i) << 32) / SINE_ENTRIES;
        quad = (u >> 30) & 3;
        v    = u & 64'h3FFF_FFFF;
        if (quad & 1)
        begin
            v = 64'h4000_0000 - v;
        end
        x    = longint'((v * 64'd1686629713) >> 30);
        x2   = x * x / Q30_L;
        term = x;
        sum  = x;
        for (int k = 1; k <= 6; k++)
        begin
            term = -(term * x2 / Q30_L) / ((2 * k) * (2 * k + 1));
            sum  = sum + term;
        end
        val = (sum * 32767 + Q30_L / 2) / Q30_L;
        if (val < 0)
        begin
            val = 0;
        end
        if (val > 32767)
        begin
            val = 32767;
        end
        if (quad >= 2)
        begin
            val = -val;
        end
        return val[15:0];
    endfunction

    function automatic logic [31:0] word_of(longint unsigned num, longint unsigned den);
        return 32'((num << 32) / den);
    endfunction

    function automatic longint tone(logic [31:0] w);
        logic [31:0] p;
        p = phase_acc * w;
        return longint'(sine_ref[(longint'(p) * SINE_ENTRIES) >> 32]);
    endfunction

    function automatic longint noise_step();
        lcg = lcg * LCG_A + LCG_C;
        return longint'(lcg[31:16]) - 32768;
    endfunction

    function automatic case_t script_case_of(int unsigned pos);
        int unsigned lens [7]  = '{40, 30, 35, 30, 30, 60, 25};
        case_t       cases [7] = '{CASE_SILENCE, CASE_SILENCE, CASE_NOISE, CASE_SPEECH,
                                   CASE_WAKE, CASE_POST, CASE_SILENCE};
        int unsigned acc;
        acc = 0;
        for (int j = 0; j < 7; j++)
        begin
            if (pos < acc + lens[j])
            begin
                return cases[j];
            end
            acc += lens[j];
        end
        return CASE_SILENCE;
    endfunction

    function automatic void predict_sample(req_t r);
        case_t       c;
        longint      total;
        longint      env;
        longint      q;
        longint      s;
        rsp_t        o;
        if (r.restart)
        begin
            lcg        = seed_reg;
            phase_acc  = 0;
            sweep_pos  = 0;
            frame_pos  = 0;
            script_pos = 0;
            return;
        end
        if (r.mode == MODE_SCRIPT)
        begin
            c = script_case_of(script_pos);
        end
        else if (r.mode <= 3'd4)
        begin
            c = case_t'(r.mode);
        end
        else
        begin
            c = CASE_SILENCE;
        end
        case (c)
            CASE_NOISE:
            begin
                total = noise_step() * 1966 * 16384;
            end
            CASE_SPEECH:
            begin
                env   = 18022 + (14746 * tone(word_of(50, 160000))) / 32768;
                total = env * (7000 * tone(word_of(1200, 160000))
                             + 3500 * tone(word_of(7000, 160000))
                             + 1800 * tone(word_of(12200, 160000)));
                total += noise_step() * 3277 * 16384;
            end
            CASE_WAKE:
            begin
                s     = sweep_pos;
                env   = 16384 + (16384 * tone(word_of(30, 160000))) / 32768;
                total = env * (6500 * tone(word_of(30000 + s, 3200000))
                             + 4200 * tone(word_of(14400 + 3 * s, 256000))
                             + 2600 * tone(word_of(192000 + 9 * s, 1280000)));
                total += noise_step() * 3932 * 16384;
            end
            CASE_POST:
            begin
                env   = 16384 + (16384 * tone(word_of(65, 160000))) / 32768;
                total = env * (6000 * tone(word_of(1650, 160000))
                             + 3000 * tone(word_of(8200, 160000))
                             + 1500 * tone(word_of(16000, 160000)));
                total += noise_step() * 3277 * 16384;
            end
            default:
            begin
                total = noise_step() * 52 * 16384;
            end
        endcase
        q = total / Q30_L;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        o.sample    = q[15:0];
        o.case_used = c;
        o.frame_end = (frame_pos + 1 >= FRAME_SAMPLES);
        if (o.frame_end)
        begin
            frame_pos = 0;
            if (r.mode == MODE_SCRIPT)
            begin
                script_pos = (script_pos + 1) % SCRIPT_FRAMES;
            end
        end
        else
        begin
            frame_pos = (frame_pos + 1) & 10'h3FF;
        end
        phase_acc = phase_acc + 1;
        sweep_pos = (sweep_pos + 1) % SWEEP_LEN;
        sample_queue.push_back(o);
    endfunction

    // sender: hold until accepted
    task automatic send_beat(logic [2:0] mode, logic restart);
        req_t r;
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        r.mode    = mode;
        r.restart = restart;
        req_valid = 1'b1;
        req       = r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        predict_sample(r);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic send_burst(int n, bit script_bias);
        logic [2:0] m;
        for (int i = 0; i < n; i++)
        begin
            m = script_bias ? MODE_SCRIPT : 3'($urandom_range(0, 7));
            send_beat(m, $urandom_range(0, 199) == 0);
        end
    endtask

    task automatic drain();
        while (sample_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_seed(logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        seed_reg    = v;
    endtask

    task automatic test_directed();
        write_seed(32'hFFFF_FFFF);
        send_beat(3'd0, 1'b1);
        for (int m = 0; m < 8; m++)
        begin
            send_beat(3'(m), 1'b0);
        end
        send_beat(3'd7, 1'b1);
        send_beat(3'd3, 1'b0);
        send_beat(3'd2, 1'b0);
        send_beat(3'd1, 1'b0);
        drain();
        write_seed(32'h0000_0000);
        send_beat(3'd5, 1'b1);
        for (int i = 0; i < 6; i++)
        begin
            send_beat(3'd5, 1'b0);
        end
    endtask

    // a frame end, reached through script-mode beats and then mixed modes
    task automatic test_script_frames();
        drain();
        write_seed($urandom);
        send_beat(3'd5, 1'b1);
        no_gaps = 1'b1;
        for (int i = 0; i < 330; i++)
        begin
            send_beat((i < 200) ? MODE_SCRIPT : 3'($urandom_range(0, 7)), 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_seed((p == 0) ? 32'h8000_0001 : $urandom);
            send_beat(3'd0, 1'b1);
            for (int b = 0; b < 10; b++)
            begin
                send_burst($urandom_range(5, 40), $urandom_range(0, 2) != 0);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        hold_off    = 1'b1;
        send_burst(30, 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (sample_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected beat: %p", rsp);
                end
            end
            else if (rsp !== sample_queue[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("beat mismatch: expected %p, got %p", sample_queue[0], rsp);
                end
                void'(sample_queue.pop_front());
            end
            else
            begin
                void'(sample_queue.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off)
        begin
            rsp_stall <= 1'b1;
            hold_cycles--;
            if (hold_cycles <= 0)
            begin
                hold_off = 1'b0;
            end
        end
        else if ((cycles / 500) % 3 == 0)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            sine_ref[i] = rom_entry(i);
        end
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_stall   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        mismatches  = 0;
        cycles      = 0;
        hold_off    = 1'b0;
        no_gaps     = 1'b0;
        seed_reg    = 0;
        phase_acc   = 0;
        lcg         = 0;
        sweep_pos   = 0;
        frame_pos   = 0;
        script_pos  = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_script_frames();
        test_backpressure();
        test_random();
        drain();
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
